// ----- src/bcc_pkg.sv -----
package bcc_pkg;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 24;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_PIP_LIMIT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_APNEA_LIMIT = 1'd1;

    localparam logic [1:0] MOVE_NONE    = 2'd0;
    localparam logic [1:0] MOVE_STOP    = 2'd1;
    localparam logic [1:0] MOVE_INHALE  = 2'd2;
    localparam logic [1:0] MOVE_EXHALE  = 2'd3;

    typedef struct packed {
        logic signed [6:0] pressure;
        logic signed [5:0] assist_level;
    } bcc_map_t;

endpackage

// ----- src/bcc_map.sv -----
module bcc_map (
    input  logic [9:0]       pressure_adc,
    input  logic [9:0]       assist_adc,
    output bcc_pkg::bcc_map_t mapped
);
    import bcc_pkg::*;

    // x / 1023 for x < 128*1023 (quotient fits 7 bits): estimate low by at most one, then correct
    function automatic logic [6:0] div1023(input logic [16:0] x);
        logic [17:0] est;
        logic [6:0]  q;
        logic [17:0] r;
        begin
            est = ({1'b0, x} + {8'd0, x[16:10]}) >> 10;
            q   = est[6:0];
            r   = {1'b0, x} - {1'b0, q, 10'd0} + {11'd0, q};
            if (r >= 18'd1023)
            begin
                q = q + 7'd1;
            end
            return q;
        end
    endfunction

    logic [16:0] p_prod;
    logic [16:0] a_prod;
    logic [6:0]  p_quot;
    logic [6:0]  a_quot;

    assign p_prod = {7'd0, pressure_adc} * 17'd100;
    assign a_prod = {7'd0, assist_adc} * 17'd21;
    assign p_quot = div1023(p_prod);
    assign a_quot = div1023(a_prod);

    assign mapped.pressure     = $signed(p_quot - 7'd50);
    assign mapped.assist_level = $signed(6'd20 - a_quot[5:0]);

endmodule

// ----- src/breath_cycle_controller.sv -----
// Path: an accepted word is held in the input register, evaluated combinationally
// and captured in the result register, which drives m_tdata.
// Throughput: one word per cycle; the input register and the result register
// part the two sides, so a stalled result stops intake only when both are full.
// Reset (rst_n low, asynchronous): phase setup, alarms disarmed and silent,
// apnea timer 0, assist level 2, pip_limit 40, apnea_limit_ms 30000.
module breath_cycle_controller (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // pressure_adc[9:0] assist_adc[19:10] elapsed_ms[27:20] set_button[28]
    // alarm_button[29] manual_trigger[30] limit_switch[31] motor_busy[32], zero pad
    input  logic [bcc_pkg::S_TDATA_W-1:0]       s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // phase[2:0] alarm_on[3] alarm_enabled[4] go_home[5] move_cmd[7:6]
    // pressure[14:8] trigger_threshold[20:15] finished[21], zero pad
    output logic [bcc_pkg::M_TDATA_W-1:0]       m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bcc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bcc_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import bcc_pkg::*;

    typedef enum logic [2:0] {
        PH_SETUP     = 3'd0,
        PH_WAIT      = 3'd1,
        PH_SWEEP_IN  = 3'd2,
        PH_SWEEP_OUT = 3'd3,
        PH_HOMING    = 3'd4,
        PH_DONE      = 3'd5
    } phase_t;

    logic                  in_valid_reg;
    logic [32:0]           in_data_reg;
    logic                  out_valid_reg;
    logic [21:0]           out_data_reg;
    logic                  advance;

    logic signed [6:0]     pip_limit_reg;
    logic [15:0]           apnea_limit_reg;

    phase_t                phase_reg, phase_next;
    logic                  armed_reg, armed_next;
    logic                  level_reg, level_next;
    logic [15:0]           timer_reg, timer_next;
    logic signed [5:0]     assist_reg;

    bcc_map_t              mapped;
    logic [16:0]           timer_sum;
    logic                  go_home;
    logic [1:0]            move_cmd;
    logic                  finished;
    logic signed [5:0]     thr;
    logic [21:0]           result;

    logic [7:0]            elapsed_ms;
    logic                  set_button, alarm_button, manual_trigger, limit_switch, motor_busy;

    assign elapsed_ms     = in_data_reg[27:20];
    assign set_button     = in_data_reg[28];
    assign alarm_button   = in_data_reg[29];
    assign manual_trigger = in_data_reg[30];
    assign limit_switch   = in_data_reg[31];
    assign motor_busy     = in_data_reg[32];

    bcc_map u_map (
        .pressure_adc (in_data_reg[9:0]),
        .assist_adc   (in_data_reg[19:10]),
        .mapped       (mapped)
    );

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {2'd0, out_data_reg};
    assign thr       = 6'sd0 - assist_reg;
    assign timer_sum = {1'b0, timer_reg} + {9'd0, elapsed_ms};

    always_comb
    begin
        phase_next = phase_reg;
        armed_next = armed_reg;
        level_next = level_reg;
        timer_next = timer_sum[16] ? 16'hFFFF : timer_sum[15:0];
        go_home    = 1'b0;
        move_cmd   = MOVE_NONE;
        finished   = 1'b0;

        if (set_button)
        begin
            level_next = 1'b0;
            go_home    = 1'b1;
            phase_next = PH_HOMING;
        end

        if ((mapped.pressure >= pip_limit_reg) && armed_next)
        begin
            level_next = 1'b1;
        end

        if (alarm_button)
        begin
            level_next = 1'b0;
            armed_next = !armed_next;
            timer_next = 16'd0;
        end

        case (phase_next)
            PH_SETUP:
            begin
                armed_next = 1'b1;
                timer_next = 16'd0;
                phase_next = PH_WAIT;
            end
            PH_WAIT:
            begin
                if ((timer_next >= apnea_limit_reg) && armed_next)
                begin
                    level_next = 1'b1;
                end
                if ((mapped.pressure <= 7'(thr)) || manual_trigger)
                begin
                    move_cmd   = MOVE_INHALE;
                    phase_next = PH_SWEEP_IN;
                end
            end
            PH_SWEEP_IN:
            begin
                if (!motor_busy)
                begin
                    move_cmd   = MOVE_EXHALE;
                    phase_next = PH_SWEEP_OUT;
                end
            end
            PH_SWEEP_OUT:
            begin
                if (!motor_busy)
                begin
                    timer_next = 16'd0;
                    phase_next = PH_WAIT;
                end
            end
            PH_HOMING:
            begin
                if (!limit_switch || !motor_busy)
                begin
                    move_cmd   = MOVE_STOP;
                    phase_next = PH_DONE;
                end
            end
            PH_DONE:
            begin
                phase_next = PH_SETUP;
                finished   = !manual_trigger;
            end
            default:
            begin
                phase_next = PH_SETUP;
            end
        endcase

        result = {finished, thr, mapped.pressure, move_cmd, go_home,
                  armed_next, level_next, phase_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            pip_limit_reg   <= 7'sd40;
            apnea_limit_reg <= 16'd30000;
            phase_reg       <= PH_SETUP;
            armed_reg       <= 1'b0;
            level_reg       <= 1'b0;
            timer_reg       <= 16'd0;
            assist_reg      <= 6'sd2;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_PIP_LIMIT:   pip_limit_reg   <= $signed(cfg_data[6:0]);
                    REG_APNEA_LIMIT: apnea_limit_reg <= cfg_data;
                    default:         ;
                endcase
            end
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                phase_reg     <= phase_next;
                armed_reg     <= armed_next;
                level_reg     <= level_next;
                timer_reg     <= timer_next;
                assist_reg    <= mapped.assist_level;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg <= s_tdata[32:0];
        end
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    // finishing always lands back in setup
    a_finish_setup: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg[21]) |-> (out_data_reg[2:0] == PH_SETUP))
        else $error("finished without return to setup");

    // set button forces homing, which may complete in the same step
    a_home_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg[5]) |->
            ((out_data_reg[2:0] == PH_HOMING) || (out_data_reg[2:0] == PH_DONE)))
        else $error("go_home outside homing");

    a_inhale_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_data_reg[7:6] == MOVE_INHALE)) |->
            (out_data_reg[2:0] == PH_SWEEP_IN))
        else $error("inhale stroke outside sweep in");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_tready)
        else $error("empty input stage not ready");

endmodule
